// ===== hw/rtl/clns_pkg.sv =====
// Package with the payload types, control word format and microcode table of the LCD sequencer.
package clns_pkg;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] byte_value;
    logic [1:0] line_number;
    logic [5:0] column_number;
  } in_item_t;

  typedef struct packed {
    logic        register_select;
    logic [3:0]  nibble;
    logic [13:0] wait_before_us;
    logic [12:0] wait_after_us;
    logic        last_strobe;
  } out_item_t;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgFunctionSet = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDisplayOff  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEntryMode   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgDisplayOn   = 2'd3;

  localparam logic [7:0] FunctionSetReset = 8'h28;
  localparam logic [7:0] DisplayOffReset  = 8'h08;
  localparam logic [7:0] EntryModeReset   = 8'h06;
  localparam logic [7:0] DisplayOnReset   = 8'h0C;

  localparam logic [2:0] ActInit    = 3'd0;
  localparam logic [2:0] ActCommand = 3'd1;
  localparam logic [2:0] ActData    = 3'd2;
  localparam logic [2:0] ActHex     = 3'd3;
  localparam logic [2:0] ActCursor  = 3'd4;

  localparam logic [7:0] CmdClear   = 8'h01;
  localparam logic [7:0] CmdHome    = 8'h02;
  localparam logic [7:0] CmdSetAddr = 8'h80;
  localparam logic [7:0] WakeNib3   = 8'h03;
  localparam logic [7:0] WakeNib2   = 8'h02;
  localparam logic [6:0] Line2Base  = 7'h40;
  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiAlpha = 8'h37;

  localparam logic [13:0] PowerUpWaitUs = 14'd16000;
  localparam logic [12:0] WaitWake0Us   = 13'd5000;
  localparam logic [12:0] WaitWake1Us   = 13'd110;
  localparam logic [12:0] WaitWake3Us   = 13'd40;
  localparam logic [12:0] WaitCmdUs     = 13'd43;
  localparam logic [12:0] WaitLongCmdUs = 13'd2043;

  typedef enum logic [3:0] {
    SRC_WAKE3,
    SRC_WAKE2,
    SRC_FSET,
    SRC_DOFF,
    SRC_CLEAR,
    SRC_ENTRY,
    SRC_DON,
    SRC_IN_BYTE,
    SRC_HEX_HI,
    SRC_HEX_LO,
    SRC_CURSOR
  } src_sel_e;

  typedef enum logic [2:0] {
    WA_NONE,
    WA_5000,
    WA_110,
    WA_40,
    WA_CMD
  } wait_sel_e;

  typedef struct packed {
    src_sel_e  src;
    logic      hi_half;
    logic      rs;
    logic      power_wait;
    wait_sel_e wait_after;
    logic      last;
  } ucode_t;

  localparam int unsigned PcW       = 5;
  localparam int unsigned UcodeLen  = 24;

  localparam logic [PcW-1:0] EntryInit    = 5'd0;
  localparam logic [PcW-1:0] EntryCommand = 5'd14;
  localparam logic [PcW-1:0] EntryData    = 5'd16;
  localparam logic [PcW-1:0] EntryHex     = 5'd18;
  localparam logic [PcW-1:0] EntryCursor  = 5'd22;

  function automatic ucode_t uw(src_sel_e src, logic hi_half, logic rs, logic power_wait,
                                wait_sel_e wait_after, logic last);
    ucode_t w;
    w.src        = src;
    w.hi_half    = hi_half;
    w.rs         = rs;
    w.power_wait = power_wait;
    w.wait_after = wait_after;
    w.last       = last;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(logic [PcW-1:0] pc);
    ucode_t w;
    case (pc)
      5'd0:    w = uw(SRC_WAKE3,   1'b0, 1'b0, 1'b1, WA_5000, 1'b0);
      5'd1:    w = uw(SRC_WAKE3,   1'b0, 1'b0, 1'b0, WA_110,  1'b0);
      5'd2:    w = uw(SRC_WAKE3,   1'b0, 1'b0, 1'b0, WA_110,  1'b0);
      5'd3:    w = uw(SRC_WAKE2,   1'b0, 1'b0, 1'b0, WA_40,   1'b0);
      5'd4:    w = uw(SRC_FSET,    1'b1, 1'b0, 1'b0, WA_NONE, 1'b0);
      5'd5:    w = uw(SRC_FSET,    1'b0, 1'b0, 1'b0, WA_CMD,  1'b0);
      5'd6:    w = uw(SRC_DOFF,    1'b1, 1'b0, 1'b0, WA_NONE, 1'b0);
      5'd7:    w = uw(SRC_DOFF,    1'b0, 1'b0, 1'b0, WA_CMD,  1'b0);
      5'd8:    w = uw(SRC_CLEAR,   1'b1, 1'b0, 1'b0, WA_NONE, 1'b0);
      5'd9:    w = uw(SRC_CLEAR,   1'b0, 1'b0, 1'b0, WA_CMD,  1'b0);
      5'd10:   w = uw(SRC_ENTRY,   1'b1, 1'b0, 1'b0, WA_NONE, 1'b0);
      5'd11:   w = uw(SRC_ENTRY,   1'b0, 1'b0, 1'b0, WA_CMD,  1'b0);
      5'd12:   w = uw(SRC_DON,     1'b1, 1'b0, 1'b0, WA_NONE, 1'b0);
      5'd13:   w = uw(SRC_DON,     1'b0, 1'b0, 1'b0, WA_CMD,  1'b1);
      5'd14:   w = uw(SRC_IN_BYTE, 1'b1, 1'b0, 1'b0, WA_NONE, 1'b0);
      5'd15:   w = uw(SRC_IN_BYTE, 1'b0, 1'b0, 1'b0, WA_CMD,  1'b1);
      5'd16:   w = uw(SRC_IN_BYTE, 1'b1, 1'b1, 1'b0, WA_NONE, 1'b0);
      5'd17:   w = uw(SRC_IN_BYTE, 1'b0, 1'b1, 1'b0, WA_NONE, 1'b1);
      5'd18:   w = uw(SRC_HEX_HI,  1'b1, 1'b1, 1'b0, WA_NONE, 1'b0);
      5'd19:   w = uw(SRC_HEX_HI,  1'b0, 1'b1, 1'b0, WA_NONE, 1'b0);
      5'd20:   w = uw(SRC_HEX_LO,  1'b1, 1'b1, 1'b0, WA_NONE, 1'b0);
      5'd21:   w = uw(SRC_HEX_LO,  1'b0, 1'b1, 1'b0, WA_NONE, 1'b1);
      5'd22:   w = uw(SRC_CURSOR,  1'b1, 1'b0, 1'b0, WA_NONE, 1'b0);
      5'd23:   w = uw(SRC_CURSOR,  1'b0, 1'b0, 1'b0, WA_CMD,  1'b1);
      default: w = uw(SRC_WAKE3,   1'b0, 1'b0, 1'b0, WA_NONE, 1'b1);
    endcase
    return w;
  endfunction

  function automatic logic [7:0] hex_ascii(logic [3:0] v);
    return (v < 4'd10) ? (AsciiZero + {4'd0, v}) : (AsciiAlpha + {4'd0, v});
  endfunction

endpackage

// ===== hw/rtl/char_lcd_nibble_sequencer_unit.sv =====
// Microcoded sequencer that turns one LCD request into its run of 4-bit strobe transfers.
// An accepted request loads the program counter and busy flag; each strobe is registered at the output.
// Throughput: one strobe per cycle, unless the output stalls, from a 24-word control table
// stepped by a program counter; a request has 14 strobes for init, 4 for hex, 2 otherwise.
// The next request is accepted in the cycle that issues the last strobe of the current one.
// Reset clears the sequencer and output valid and loads the power-on initialization commands.
module char_lcd_nibble_sequencer_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  clns_pkg::in_item_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output clns_pkg::out_item_t       out_data_o,
  input  logic                      cfg_we_i,
  input  logic [clns_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [clns_pkg::CfgDataW-1:0] cfg_data_i
);
  import clns_pkg::*;

  logic           busy_q, busy_d;
  logic [PcW-1:0] pc_q, pc_d;
  in_item_t       item_q;
  logic [7:0]     fset_q, doff_q, entry_q, don_q;
  logic           out_valid_q, out_valid_d;
  out_item_t      out_q, out_d;

  ucode_t         uword;
  logic           step;
  logic           in_accept;
  logic           act_known;
  logic [PcW-1:0] entry_pc;
  logic [7:0]     sel_byte;
  logic [6:0]     cursor_addr;
  logic [6:0]     line_base;
  logic [12:0]    wait_after;

  assign uword     = ucode_rom(pc_q);
  assign step      = busy_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = busy_q && !(step && uword.last);
  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    act_known = 1'b1;
    entry_pc  = EntryInit;
    case (in_data_i.action)
      ActInit:    entry_pc = EntryInit;
      ActCommand: entry_pc = EntryCommand;
      ActData:    entry_pc = EntryData;
      ActHex:     entry_pc = EntryHex;
      ActCursor:  entry_pc = EntryCursor;
      default:    act_known = 1'b0;
    endcase
  end

  assign line_base   = (item_q.line_number == 2'd1) ? 7'd0 : Line2Base;
  assign cursor_addr = line_base + {1'b0, item_q.column_number} - 7'd1;

  always_comb begin
    unique case (uword.src)
      SRC_WAKE3:   sel_byte = WakeNib3;
      SRC_WAKE2:   sel_byte = WakeNib2;
      SRC_FSET:    sel_byte = fset_q;
      SRC_DOFF:    sel_byte = doff_q;
      SRC_CLEAR:   sel_byte = CmdClear;
      SRC_ENTRY:   sel_byte = entry_q;
      SRC_DON:     sel_byte = don_q;
      SRC_IN_BYTE: sel_byte = item_q.byte_value;
      SRC_HEX_HI:  sel_byte = hex_ascii(item_q.byte_value[7:4]);
      SRC_HEX_LO:  sel_byte = hex_ascii(item_q.byte_value[3:0]);
      SRC_CURSOR:  sel_byte = CmdSetAddr | {1'b0, cursor_addr};
      default:     sel_byte = '0;
    endcase
  end

  always_comb begin
    unique case (uword.wait_after)
      WA_NONE: wait_after = '0;
      WA_5000: wait_after = WaitWake0Us;
      WA_110:  wait_after = WaitWake1Us;
      WA_40:   wait_after = WaitWake3Us;
      WA_CMD:  wait_after = (sel_byte == CmdClear || sel_byte == CmdHome) ?
                            WaitLongCmdUs : WaitCmdUs;
      default: wait_after = '0;
    endcase
  end

  always_comb begin
    out_d.register_select = uword.rs;
    out_d.nibble          = uword.hi_half ? sel_byte[7:4] : sel_byte[3:0];
    out_d.wait_before_us  = uword.power_wait ? PowerUpWaitUs : 14'd0;
    out_d.wait_after_us   = wait_after;
    out_d.last_strobe     = uword.last;
  end

  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (step) begin
      out_valid_d = 1'b1;
      pc_d        = pc_q + PcW'(1);
      if (uword.last) begin
        busy_d = 1'b0;
      end
    end
    if (in_accept && act_known) begin
      busy_d = 1'b1;
      pc_d   = entry_pc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
      fset_q      <= FunctionSetReset;
      doff_q      <= DisplayOffReset;
      entry_q     <= EntryModeReset;
      don_q       <= DisplayOnReset;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgFunctionSet: fset_q  <= cfg_data_i;
          CfgDisplayOff:  doff_q  <= cfg_data_i;
          CfgEntryMode:   entry_q <= cfg_data_i;
          CfgDisplayOn:   don_q   <= cfg_data_i;
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    if (step) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_pc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q < PcW'(UcodeLen)))
    else $error("program counter outside the control table");

  a_stall_holds_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && out_valid_o && out_stall_i) |=> $stable(pc_q))
    else $error("sequencer advanced while the output was stalled");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && uword.last && !in_accept) |=> !busy_q)
    else $error("sequencer still busy after the last strobe");

  a_unknown_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !act_known) |=> !busy_q)
    else $error("unknown action started a sequence");

  a_step_gives_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("strobe issued without an output transfer");
`endif

endmodule

// ===== tb/lcd_strobe_checker.sv =====
// Checker that predicts the LCD strobe transfers of each accepted request and compares them.
module lcd_strobe_checker
  import clns_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_item_t             out_data_i,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  output int unsigned           error_count_o,
  output int unsigned           pending_o
);

  logic [7:0]  function_set_cmd;
  logic [7:0]  display_off_cmd;
  logic [7:0]  entry_mode_cmd;
  logic [7:0]  display_on_cmd;
  out_item_t   expected_strobes[$];
  int unsigned fail_count = 0;
  int unsigned pending_count = 0;

  assign error_count_o = fail_count;
  assign pending_o     = pending_count;

  function void push_strobe(logic rs, logic [3:0] nib, logic [13:0] pre, logic [12:0] post,
                            logic fin);
    out_item_t s;
    s.register_select = rs;
    s.nibble          = nib;
    s.wait_before_us  = pre;
    s.wait_after_us   = post;
    s.last_strobe     = fin;
    expected_strobes.push_back(s);
  endfunction

  function void push_byte(logic rs, logic [7:0] b, logic [12:0] post, logic fin);
    push_strobe(rs, b[7:4], 14'd0, 13'd0, 1'b0);
    push_strobe(rs, b[3:0], 14'd0, post, fin);
  endfunction

  function void push_command(logic [7:0] cmd, logic fin);
    push_byte(1'b0, cmd, (cmd == CmdClear || cmd == CmdHome) ? WaitLongCmdUs : WaitCmdUs, fin);
  endfunction

  function logic [7:0] ascii_digit(logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + {4'd0, v} : 8'h41 + {4'd0, v} - 8'd10;
  endfunction

  function void predict_strobes(in_item_t req);
    logic [6:0] base;
    logic [6:0] addr;
    case (req.action)
      ActInit: begin
        push_strobe(1'b0, WakeNib3[3:0], PowerUpWaitUs, WaitWake0Us, 1'b0);
        push_strobe(1'b0, WakeNib3[3:0], 14'd0, WaitWake1Us, 1'b0);
        push_strobe(1'b0, WakeNib3[3:0], 14'd0, WaitWake1Us, 1'b0);
        push_strobe(1'b0, WakeNib2[3:0], 14'd0, WaitWake3Us, 1'b0);
        push_command(function_set_cmd, 1'b0);
        push_command(display_off_cmd, 1'b0);
        push_command(CmdClear, 1'b0);
        push_command(entry_mode_cmd, 1'b0);
        push_command(display_on_cmd, 1'b1);
      end
      ActCommand: begin
        push_command(req.byte_value, 1'b1);
      end
      ActData: begin
        push_byte(1'b1, req.byte_value, 13'd0, 1'b1);
      end
      ActHex: begin
        push_byte(1'b1, ascii_digit(req.byte_value[7:4]), 13'd0, 1'b0);
        push_byte(1'b1, ascii_digit(req.byte_value[3:0]), 13'd0, 1'b1);
      end
      ActCursor: begin
        base = (req.line_number == 2'd1) ? 7'h00 : Line2Base;
        addr = base + {1'b0, req.column_number} - 7'd1;
        push_command(CmdSetAddr | {1'b0, addr}, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    if (fail_count < 10) begin
      $display("Mismatch in %s: expected %0d, got %0d", field, want, got);
    end
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      function_set_cmd = FunctionSetReset;
      display_off_cmd  = DisplayOffReset;
      entry_mode_cmd   = EntryModeReset;
      display_on_cmd   = DisplayOnReset;
      expected_strobes.delete();
      pending_count = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgFunctionSet: function_set_cmd = cfg_data_i;
          CfgDisplayOff:  display_off_cmd  = cfg_data_i;
          CfgEntryMode:   entry_mode_cmd   = cfg_data_i;
          CfgDisplayOn:   display_on_cmd   = cfg_data_i;
          default: begin
          end
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_strobes.size() == 0) begin
          if (fail_count < 10) begin
            $display("Strobe transfer with nothing expected: nibble %0h", out_data_i.nibble);
          end
          fail_count++;
        end else begin
          want = expected_strobes.pop_front();
          if (out_data_i.register_select !== want.register_select) begin
            flag_mismatch("register_select", want.register_select, out_data_i.register_select);
          end
          if (out_data_i.nibble !== want.nibble) begin
            flag_mismatch("nibble", want.nibble, out_data_i.nibble);
          end
          if (out_data_i.wait_before_us !== want.wait_before_us) begin
            flag_mismatch("wait_before_us", want.wait_before_us, out_data_i.wait_before_us);
          end
          if (out_data_i.wait_after_us !== want.wait_after_us) begin
            flag_mismatch("wait_after_us", want.wait_after_us, out_data_i.wait_after_us);
          end
          if (out_data_i.last_strobe !== want.last_strobe) begin
            flag_mismatch("last_strobe", want.last_strobe, out_data_i.last_strobe);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_strobes(in_data_i);
      end
      pending_count = expected_strobes.size();
    end
  end

endmodule

// ===== tb/tb_char_lcd_nibble_sequencer_unit.sv =====
// Top-level testbench that drives requests and configuration into the LCD sequencer.
module tb_char_lcd_nibble_sequencer_unit;
  import clns_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [2:0]  ActFirstUnused = ActCursor + 3'd1;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  int unsigned         error_count;
  int unsigned         pending;
  int unsigned         cycle_count = 0;
  logic                drain_mode = 1'b0;

  char_lcd_nibble_sequencer_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  lcd_strobe_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned burst;
    @(negedge clk);
    forever begin
      if (drain_mode) begin
        out_stall <= 1'b0;
        @(negedge clk);
      end else begin
        burst = $urandom_range(1, 15);
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat (burst) @(negedge clk);
      end
    end
  end

  task automatic send_request(input logic [2:0] act, input logic [7:0] b,
                              input logic [1:0] line, input logic [5:0] col);
    in_item_t req;
    req.action        = act;
    req.byte_value    = b;
    req.line_number   = line;
    req.column_number = col;
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (!drain_mode && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_registers(input logic [7:0] fset, input logic [7:0] doff,
                                   input logic [7:0] entry, input logic [7:0] don);
    logic [7:0] values[4];
    values = '{fset, doff, entry, don};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CfgIdxW'(i);
      cfg_data  <= values[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_random_request();
    int unsigned pick;
    logic [2:0]  act;
    logic [7:0]  b;
    logic [1:0]  line;
    logic [5:0]  col;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      act = ActInit;
    end else if (pick < 28) begin
      act = ActCommand;
    end else if (pick < 50) begin
      act = ActData;
    end else if (pick < 72) begin
      act = ActHex;
    end else if (pick < 94) begin
      act = ActCursor;
    end else begin
      act = ActFirstUnused + 3'($urandom_range(0, 2));
    end
    b    = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 2)) : 8'($urandom_range(0, 255));
    line = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(0, 3)) : 2'($urandom_range(1, 2));
    col  = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 40));
    send_request(act, b, line, col);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(ActInit, 8'h00, 2'd1, 6'd1);
    send_request(ActCommand, 8'h00, 2'd0, 6'd0);
    send_request(ActCommand, 8'hFF, 2'd3, 6'd63);
    send_request(ActCommand, CmdClear, 2'd1, 6'd1);
    send_request(ActCommand, CmdHome, 2'd1, 6'd1);
    send_request(ActCommand, 8'h03, 2'd1, 6'd1);
    send_request(ActData, 8'h00, 2'd1, 6'd1);
    send_request(ActData, 8'hFF, 2'd2, 6'd40);
    send_request(ActHex, 8'h00, 2'd1, 6'd1);
    send_request(ActHex, 8'hFF, 2'd1, 6'd1);
    send_request(ActHex, 8'h9A, 2'd1, 6'd1);
    send_request(ActHex, 8'hA9, 2'd1, 6'd1);
    send_request(ActCursor, 8'h00, 2'd1, 6'd1);
    send_request(ActCursor, 8'h00, 2'd1, 6'd40);
    send_request(ActCursor, 8'h00, 2'd2, 6'd1);
    send_request(ActCursor, 8'h00, 2'd2, 6'd40);
    send_request(ActCursor, 8'h00, 2'd1, 6'd0);
    send_request(ActCursor, 8'h00, 2'd2, 6'd0);
    send_request(ActCursor, 8'hFF, 2'd0, 6'd63);
    send_request(ActCursor, 8'hFF, 2'd3, 6'd63);
    send_request(ActFirstUnused, 8'hFF, 2'd3, 6'd63);
    send_request(ActFirstUnused + 3'd1, 8'h55, 2'd1, 6'd1);
    send_request(ActFirstUnused + 3'd2, 8'hAA, 2'd2, 6'd21);

    settle();
    program_registers(8'h00, 8'h00, 8'h00, 8'h00);
    send_request(ActInit, 8'h00, 2'd1, 6'd1);
    repeat (3) send_random_request();

    settle();
    program_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_request(ActInit, 8'hFF, 2'd1, 6'd1);
    repeat (3) send_random_request();

    settle();
    program_registers(CmdClear, CmdHome, CmdClear, CmdHome);
    send_request(ActInit, 8'h00, 2'd2, 6'd1);
    repeat (3) send_random_request();

    for (int phase = 0; phase < 4; phase++) begin
      settle();
      program_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      drain_mode = (phase == 3);
      repeat (80) send_random_request();
    end

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/clns_pkg.sv
hw/rtl/char_lcd_nibble_sequencer_unit.sv
tb/lcd_strobe_checker.sv
tb/tb_char_lcd_nibble_sequencer_unit.sv
